### rtl/core/assert_macros.svh
// Assertion macros used by the termination detector top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define TRTD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define TRTD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

### rtl/core/trtd_pkg.sv
// Types and constants of the token ring termination detector
package trtd_pkg;

  localparam int unsigned TargetW  = 31;
  localparam int unsigned RankW    = 6;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned CountW   = 16;
  localparam int unsigned BalW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned StepCntW = 5;

  // Request kinds
  localparam logic [2:0] KindPush  = 3'd0;
  localparam logic [2:0] KindLift  = 3'd1;
  localparam logic [2:0] KindRecv  = 3'd2;
  localparam logic [2:0] KindToken = 3'd3;
  localparam logic [2:0] KindTerm  = 3'd4;
  localparam logic [2:0] KindIdle  = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNodeRank = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRingSize = 2'd1;

  typedef struct packed {
    logic [2:0]                kind;
    logic [TargetW-1:0]        target_node;
    logic [CountW-1:0]         msg_count;
    logic                      in_token_color;
    logic signed [BalW-1:0]    in_token_value;
  } in_req_t;

  typedef struct packed {
    logic                      push_remote;
    logic [RankW-1:0]          push_owner;
    logic                      token_send;
    logic                      out_token_color;
    logic signed [BalW-1:0]    out_token_value;
    logic [RankW-1:0]          token_dest;
    logic                      term_broadcast;
    logic                      is_terminated;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch request, seed the remainder unit
    logic step;   // one restoring-remainder step
    logic exec;   // update state, write result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_div;
  } dp_status_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StExec = 3'b100
  } ctrl_state_e;

endpackage

### rtl/core/trtd_dp.sv
// Datapath: config registers, request latch, remainder unit, node state, result register
module trtd_dp import trtd_pkg::*; #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_req_t             in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [SizeW-1:0]    cfg_data_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output out_res_t            out_data_o
);

  localparam int unsigned SizeCap = (MAX_NODES > (2 ** SizeW - 1)) ? (2 ** SizeW - 1) : MAX_NODES;
  localparam logic [SizeW-1:0] SizeCapV = SizeW'(SizeCap);

  logic [RankW-1:0]   rank_q;
  logic [SizeW-1:0]   size_q;
  logic [SizeW-1:0]   eff_size;
  in_req_t            req_q;
  logic [TargetW-1:0] dvd_q, dvd_d;
  logic [SizeW-1:0]   rem_q, rem_d;
  logic [SizeW:0]     trial;
  logic [SizeW:0]     trial_sub;

  logic [BalW-1:0]    bal_q, bal_d;
  logic               black_q, black_d;
  logic               held_q, held_d;
  logic               sent_q, sent_d;
  logic               hcolor_q, hcolor_d;
  logic [BalW-1:0]    hvalue_q, hvalue_d;
  logic               done_q, done_d;
  out_res_t           out_q, out_d;

  logic               master;
  logic               holding;
  logic               remote;
  logic [BalW-1:0]    tok_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
      size_q <= SizeW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgNodeRank: rank_q <= cfg_data_i[RankW-1:0];
        CfgRingSize: size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring size clamped to 1..min(MAX_NODES, 127)
  always_comb begin
    eff_size = size_q;
    if (size_q == '0) eff_size = SizeW'(1);
    else if (size_q > SizeCapV) eff_size = SizeCapV;
  end

  assign master = (rank_q == '0);
  assign status_o.needs_div = (req_q.kind == KindPush) || (req_q.kind == KindIdle);

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
  end

  // Restoring remainder: one dividend bit per step
  assign trial     = {rem_q, dvd_q[TargetW-1]};
  assign trial_sub = trial - {1'b0, eff_size};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      rem_d = '0;
      if (in_data_i.kind == KindPush) begin
        dvd_d = in_data_i.target_node;
      end else begin
        dvd_d = TargetW'({1'b0, rank_q} + SizeW'(1));
      end
    end else if (cmd_i.step) begin
      dvd_d = {dvd_q[TargetW-2:0], 1'b0};
      rem_d = (trial >= {1'b0, eff_size}) ? trial_sub[SizeW-1:0] : trial[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // Node state update and result for the latched request
  assign remote  = (rem_q != {1'b0, rank_q});
  assign holding = held_q || (master && !sent_q);
  assign tok_sum = hvalue_q + bal_q;

  always_comb begin
    bal_d    = bal_q;
    black_d  = black_q;
    held_d   = held_q;
    sent_d   = sent_q;
    hcolor_d = hcolor_q;
    hvalue_d = hvalue_q;
    done_d   = done_q;
    out_d    = '0;
    case (req_q.kind)
      KindPush: begin
        bal_d = bal_q + BalW'(remote);
        out_d.push_remote = remote;
        out_d.push_owner  = rem_q[RankW-1:0];
      end
      KindLift: begin
        bal_d = bal_q + BalW'(req_q.msg_count);
      end
      KindRecv: begin
        if (req_q.msg_count != '0) begin
          bal_d   = bal_q - BalW'(req_q.msg_count);
          black_d = 1'b1;
        end
      end
      KindToken: begin
        hcolor_d = req_q.in_token_color | black_q;
        hvalue_d = req_q.in_token_value;
        black_d  = 1'b0;
        held_d   = 1'b1;
      end
      KindTerm: begin
        done_d = 1'b1;
      end
      KindIdle: begin
        if (!done_q && holding) begin
          if (master && sent_q && !black_q && !hcolor_q && (tok_sum == '0)) begin
            done_d = 1'b1;
            out_d.term_broadcast = 1'b1;
          end else begin
            // master restarts a fresh white token
            hcolor_d = master ? 1'b0 : hcolor_q;
            hvalue_d = master ? '0 : tok_sum;
            held_d   = 1'b0;
            sent_d   = 1'b1;
            out_d.token_send      = 1'b1;
            out_d.out_token_color = master ? 1'b0 : hcolor_q;
            out_d.out_token_value = master ? '0 : tok_sum;
            out_d.token_dest      = rem_q[RankW-1:0];
          end
        end
      end
      default: ;
    endcase
    out_d.is_terminated = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_q    <= '0;
      black_q  <= 1'b0;
      held_q   <= 1'b0;
      sent_q   <= 1'b0;
      hcolor_q <= 1'b0;
      hvalue_q <= '0;
      done_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      bal_q    <= bal_d;
      black_q  <= black_d;
      held_q   <= held_d;
      sent_q   <= sent_d;
      hcolor_q <= hcolor_d;
      hvalue_q <= hvalue_d;
      done_q   <= done_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/trtd_ctrl.sv
// Controller: request sequencing, step counter and result valid
module trtd_ctrl import trtd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  dp_status_t  status_i,
  output dp_cmd_t     cmd_o
);

  localparam logic [StepCntW-1:0] LastStep = StepCntW'(TargetW - 1);

  ctrl_state_e         state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                ovalid_q, ovalid_d;
  logic                out_free;

  assign out_free = !ovalid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        if (!status_i.needs_div) begin
          state_d = StExec;
        end else begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + StepCntW'(1);
          if (cnt_q == LastStep) state_d = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result valid: set on execute, cleared when taken
  always_comb begin
    ovalid_d = ovalid_q && out_stall_i;
    if (cmd_o.exec) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ovalid_q;

endmodule

### rtl/core/token_ring_termination_detector.sv
// Top level of one token ring termination detector node
//
// Usage: requests enter on in_valid_i/in_stall_o with one in_req_t each
// (push, lift fan-out, receipt, token arrival, termination, idle check).
// Every request gives exactly one out_res_t on out_valid_o/out_stall_i.
// Node rank and ring size are written through cfg_valid_i/cfg_ready_o;
// the user must do so only while no request is in flight, as the block
// does not enforce it; cfg_ready_o is always high.
// Push and idle check run 31 steps of the restoring remainder unit, one bit
// of the 31-bit target or of rank+1 per step, before execute; other kinds
// go straight to execute. One request is in flight at a time; a new one is
// accepted the cycle after the result is written.
// A finished result waits in the output register while the next request
// is accepted; if the receiver still stalls when that one is done, the
// block holds it in the execute step, with in_stall_o high, until the
// output register is free.
// Reset clears the node state (balance, colors, token, done flag), sets
// rank 0 and ring size 1, and leaves the block ready for requests.
module token_ring_termination_detector import trtd_pkg::*; #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_res_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [SizeW-1:0]    cfg_data_i
);

  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  trtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  trtd_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  // An accepted request keeps the block busy in the next cycle
  `TRTD_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "request accepted while idle did not make the block busy")
  // A new result only comes from a request in flight
  `TRTD_ASSERT(a_result_from_request, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without a request in flight")
  // Execute never overwrites a result that is still stalled
  `TRTD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.exec && out_valid_o && out_stall_i, "result register overwritten while stalled")

endmodule

### dv/token_ring_termination_detector_tb.sv
// Testbench of one token ring termination detector node: directed and random requests
`timescale 1ns / 100ps

module token_ring_termination_detector_tb;
  import trtd_pkg::*;

  localparam int unsigned MaxNodes    = 64;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned PhaseItems  = 175;

  // Kinds outside the defined set, the block must ignore them
  localparam logic [2:0] KindRsvdA = 3'd6;
  localparam logic [2:0] KindRsvdB = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_req_t            in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_res_t           out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SizeW-1:0]   cfg_data_i = '0;

  // Node state as the checker sees it
  logic [RankW-1:0] rank_cfg = '0;
  logic [SizeW-1:0] size_cfg = 7'd1;
  logic [BalW-1:0]  bal_q = '0;
  logic             node_is_black = 1'b0;
  logic             holds_token = 1'b0;
  logic             first_token_gone = 1'b0;
  logic             tok_color = 1'b0;
  logic [BalW-1:0]  tok_value = '0;
  logic             terminated = 1'b0;

  out_res_t    expected_results[$];
  int unsigned mismatches = 0;
  logic        idling = 1'b1;
  int unsigned stall_left = 0;

  token_ring_termination_detector #(
    .MAX_NODES(MaxNodes)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Ring size clamped to 1..MaxNodes
  function automatic int unsigned ring_span();
    if (size_cfg == 0) return 1;
    if (size_cfg > MaxNodes) return MaxNodes;
    return size_cfg;
  endfunction

  // Advance the node state by one request and return the result it gives
  function automatic out_res_t predict_node_step(input in_req_t req);
    out_res_t         res;
    int unsigned      span;
    logic [RankW-1:0] owner;
    logic             is_master;
    logic             holding;
    logic [BalW-1:0]  sum;
    logic             color;
    res       = '0;
    span      = ring_span();
    is_master = (rank_cfg == 0);
    case (req.kind)
      KindPush: begin
        owner = RankW'(req.target_node % span);
        res.push_remote = (owner != rank_cfg);
        res.push_owner  = owner;
        if (owner != rank_cfg) bal_q = bal_q + 1;
      end
      KindLift: begin
        bal_q = bal_q + BalW'(req.msg_count);
      end
      KindRecv: begin
        if (req.msg_count != 0) begin
          bal_q = bal_q - BalW'(req.msg_count);
          node_is_black = 1'b1;
        end
      end
      KindToken: begin
        tok_color = req.in_token_color;
        tok_value = req.in_token_value;
        // a black node taints the token and turns white
        if (node_is_black) begin
          tok_color = 1'b1;
          node_is_black = 1'b0;
        end
        holds_token = 1'b1;
      end
      KindTerm: begin
        terminated = 1'b1;
      end
      KindIdle: begin
        holding = holds_token || (is_master && !first_token_gone);
        if (!terminated && holding) begin
          if (is_master && first_token_gone && !node_is_black && !tok_color &&
              (tok_value + bal_q) == 0) begin
            terminated = 1'b1;
            res.term_broadcast = 1'b1;
          end else begin
            sum   = tok_value + bal_q;
            color = tok_color;
            // master starts a fresh white round
            if (is_master) begin
              sum   = '0;
              color = 1'b0;
            end
            tok_color = color;
            tok_value = sum;
            holds_token = 1'b0;
            first_token_gone = 1'b1;
            res.token_send      = 1'b1;
            res.out_token_color = color;
            res.out_token_value = sum;
            res.token_dest      = RankW'((int'(rank_cfg) + 1) % span);
          end
        end
      end
      default: ;
    endcase
    res.is_terminated = terminated;
    return res;
  endfunction

  function automatic in_req_t make_request(input logic [2:0] kind,
                                           input logic [TargetW-1:0] target = '0,
                                           input logic [CountW-1:0] count = '0,
                                           input logic color = 1'b0,
                                           input logic [BalW-1:0] value = '0);
    in_req_t req;
    req.kind           = kind;
    req.target_node    = target;
    req.msg_count      = count;
    req.in_token_color = color;
    req.in_token_value = value;
    return req;
  endfunction

  // Random request of the given kind; unused fields carry random junk
  function automatic in_req_t random_request(input logic [2:0] kind);
    in_req_t     req;
    int unsigned pick;
    req.kind           = kind;
    req.target_node    = TargetW'($urandom);
    req.msg_count      = CountW'($urandom);
    req.in_token_color = 1'($urandom);
    req.in_token_value = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // lands on this node when the rank is inside the ring
      req.target_node = TargetW'(rank_cfg + ring_span() * $urandom_range(0, 1000));
    end else if (pick < 50) begin
      req.target_node = TargetW'($urandom_range(0, 200));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) req.msg_count = CountW'($urandom_range(0, 20));
    else if (pick < 70) req.msg_count = '1;
    // near miss of a zero sum keeps the ring going
    if ($urandom_range(0, 99) < 40) req.in_token_value = 0 - bal_q + $urandom_range(1, 3);
    return req;
  endfunction

  function automatic logic [2:0] counting_kind();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return KindPush;
    if (pick < 70) return KindLift;
    if (pick < 95) return KindRecv;
    return (pick < 98) ? KindRsvdA : KindRsvdB;
  endfunction

  function automatic logic [2:0] noise_kind();
    case ($urandom_range(0, 6))
      0: return KindPush;
      1: return KindLift;
      2: return KindRecv;
      3: return KindToken;
      4: return KindIdle;
      5: return KindRsvdA;
      default: return KindRsvdB;
    endcase
  endfunction

  // Send one request, record its expected result on acceptance
  task automatic issue_request(input in_req_t req);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_node_step(req));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Rank and size are only rewritten with nothing in flight
  task automatic set_ring(input logic [RankW-1:0] rank, input logic [SizeW-1:0] ring_n);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgNodeRank;
    cfg_data_i  <= SizeW'(rank);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rank_cfg = rank;
    cfg_index_i <= CfgRingSize;
    cfg_data_i  <= ring_n;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    size_cfg = ring_n;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Master's initial token, counting events, reserved kinds
  task automatic test_first_token_and_counts();
    set_ring(6'd0, 7'd4);
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindPush, 31'd0));
    issue_request(make_request(KindPush, 31'h7FFF_FFFF));
    issue_request(make_request(KindLift, '0, 16'hFFFF));
    issue_request(make_request(KindLift, '0, 16'd0));
    issue_request(make_request(KindRecv, '0, 16'd0));
    issue_request(make_request(KindRecv, '0, 16'hFFFF));
    issue_request(make_request(KindRsvdA, '1, '1, 1'b1, '1));
    issue_request(make_request(KindRsvdB));
  endtask

  // Non-master forwarding: tainted token, overwrite while held, balance wrap
  task automatic test_token_forwarding();
    set_ring(6'd5, 7'd8);
    issue_request(make_request(KindToken, '0, '0, 1'b0, 32'h7FFF_FFFF));
    issue_request(make_request(KindToken, '0, '0, 1'b0, 32'h7FFF_FFFF));
    issue_request(make_request(KindLift, '0, 16'd5));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindRecv, '0, 16'd100));
    issue_request(make_request(KindToken, '0, '0, 1'b1, 32'h8000_0000));
    issue_request(make_request(KindIdle));
  endtask

  // Size clamping at both ends and a rank outside the ring
  task automatic test_ring_clamping();
    set_ring(6'd63, 7'd0);
    issue_request(make_request(KindPush, 31'd0));
    issue_request(make_request(KindPush, 31'h5555_5555));
    issue_request(make_request(KindToken));
    issue_request(make_request(KindIdle));
    set_ring(6'd63, 7'd127);
    issue_request(make_request(KindPush, 31'd63));
    issue_request(make_request(KindPush, 31'h7FFF_FFFE));
    issue_request(make_request(KindToken, '0, '0, 1'b0, 32'd1));
    issue_request(make_request(KindIdle));
  endtask

  // Mostly token rounds (arrival, counting events, idle check), some noise
  task automatic test_random_rounds(input logic [RankW-1:0] rank,
                                    input logic [SizeW-1:0] ring_n);
    int unsigned sent;
    sent = 0;
    set_ring(rank, ring_n);
    while (sent < PhaseItems) begin
      if ($urandom_range(0, 9) < 7) begin
        issue_request(random_request(KindToken));
        sent++;
        repeat ($urandom_range(0, 6)) begin
          issue_request(random_request(counting_kind()));
          sent++;
        end
        issue_request(random_request(KindIdle));
        sent++;
      end else begin
        issue_request(random_request(noise_kind()));
        sent++;
      end
    end
  endtask

  // Master rounds ending in a termination broadcast, then events after it
  task automatic test_termination();
    idling = 1'b0;
    set_ring(6'd0, 7'd4);
    issue_request(make_request(KindToken, '0, '0, 1'b1, 32'd7));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindRecv, '0, 16'd3));
    issue_request(make_request(KindToken, '0, '0, 1'b0, 0 - bal_q));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindToken, '0, '0, 1'b0, 1 - bal_q));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindToken, '0, '0, 1'b0, 0 - bal_q));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindIdle));
    issue_request(make_request(KindPush, 31'd1));
    issue_request(make_request(KindLift, '0, 16'd2));
    issue_request(make_request(KindTerm));
    issue_request(make_request(KindRsvdA));
    issue_request(make_request(KindIdle));
  endtask

  // Receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    out_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, out_data_o);
      end else begin
        want = expected_results.pop_front();
        cmp_field("push_remote", want.push_remote, out_data_o.push_remote);
        cmp_field("push_owner", want.push_owner, out_data_o.push_owner);
        cmp_field("token_send", want.token_send, out_data_o.token_send);
        cmp_field("out_token_color", want.out_token_color, out_data_o.out_token_color);
        cmp_field("out_token_value", want.out_token_value, out_data_o.out_token_value);
        cmp_field("token_dest", want.token_dest, out_data_o.token_dest);
        cmp_field("term_broadcast", want.term_broadcast, out_data_o.term_broadcast);
        cmp_field("is_terminated", want.is_terminated, out_data_o.is_terminated);
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_token_and_counts();
    test_token_forwarding();
    test_ring_clamping();
    test_random_rounds(6'd0, 7'd64);
    test_random_rounds(6'd63, 7'd64);
    test_random_rounds(6'd5, 7'd8);
    test_random_rounds(6'd10, 7'd4);
    test_random_rounds(6'd0, 7'd1);
    test_random_rounds(6'd63, 7'd0);
    test_random_rounds(6'd40, 7'd127);
    test_random_rounds(RankW'($urandom), SizeW'($urandom_range(1, 64)));
    test_termination();
    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
